@@ rtl/core/matrix_multiply_with_transpose_modes_defines.svh @@
// Assertion macros for the matrix multiply block.
`ifndef MATRIX_MULTIPLY_WITH_TRANSPOSE_MODES_DEFINES_SVH
`define MATRIX_MULTIPLY_WITH_TRANSPOSE_MODES_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MMT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MMT_ASSERT(lbl, prop, msg)
`define MMT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/mmt_pkg.sv @@
// Shared types and constants for the matrix multiply block.
`timescale 1ns / 1ps
package mmt_pkg;

  localparam int MAX_DIM_DEFAULT = 16;
  localparam int FIELD_CAP = 16;
  localparam int IDX_W = 4;
  localparam int DIM_W = 5;
  localparam int VAL_W = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W = 36;
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_WR_A = 2'd0,
    KIND_WR_B = 2'd1,
    KIND_ROW  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_AB  = 2'd0,
    MODE_ATB = 2'd1,
    MODE_ABT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE    = 2'd0,
    REG_ROWS_M  = 2'd1,
    REG_INNER_K = 2'd2,
    REG_COLS_N  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    mode_t            md;
    logic [DIM_W-1:0] m;
    logic [DIM_W-1:0] k;
    logic [DIM_W-1:0] n;
  } cfg_t;

  typedef struct packed {
    kind_t                   op;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [ACC_W-1:0] value;
    logic                    last;
  } res_t;

endpackage

@@ rtl/core/mmt_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module mmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/mmt_fifo.sv @@
// Small register FIFO with occupancy count.
`timescale 1ns / 1ps
module mmt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

endmodule

@@ rtl/core/mmt_front.sv @@
// Front end: accepts beats, drops out-of-shape ones, queues commands.
`timescale 1ns / 1ps
module mmt_front (
  input  logic                              clk,
  input  logic                              rst,
  input  mmt_pkg::cfg_t                     cfg,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        kind,
  input  logic [mmt_pkg::IDX_W-1:0]         row,
  input  logic [mmt_pkg::IDX_W-1:0]         col,
  input  logic signed [mmt_pkg::VAL_W-1:0]  value,
  output mmt_pkg::cmd_t                     cmd,
  output logic                              cmd_valid,
  input  logic                              cmd_pop
);

  localparam int CW = $clog2(mmt_pkg::CMD_DEPTH + 1);

  logic [mmt_pkg::DIM_W-1:0] a_rows;
  logic [mmt_pkg::DIM_W-1:0] a_cols;
  logic [mmt_pkg::DIM_W-1:0] b_rows;
  logic [mmt_pkg::DIM_W-1:0] b_cols;
  logic [mmt_pkg::DIM_W-1:0] row_w;
  logic [mmt_pkg::DIM_W-1:0] col_w;
  logic                      keep;
  logic                      q_empty;
  logic [CW-1:0]             q_count;
  mmt_pkg::cmd_t             cmd_in;

  assign row_w = mmt_pkg::DIM_W'(row);
  assign col_w = mmt_pkg::DIM_W'(col);

  // stored operand shapes per mode
  always_comb begin
    a_rows = (cfg.md == mmt_pkg::MODE_ATB) ? cfg.k : cfg.m;
    a_cols = (cfg.md == mmt_pkg::MODE_ATB) ? cfg.m : cfg.k;
    b_rows = (cfg.md == mmt_pkg::MODE_ABT) ? cfg.n : cfg.k;
    b_cols = (cfg.md == mmt_pkg::MODE_ABT) ? cfg.k : cfg.n;
  end

  always_comb begin
    unique case (kind)
      mmt_pkg::KIND_WR_A: keep = (row_w < a_rows) && (col_w < a_cols);
      mmt_pkg::KIND_WR_B: keep = (row_w < b_rows) && (col_w < b_cols);
      mmt_pkg::KIND_ROW:  keep = (row_w < cfg.m) && (cfg.n != '0);
      default:            keep = 1'b0;
    endcase
  end

  assign cmd_in.op    = mmt_pkg::kind_t'(kind);
  assign cmd_in.row   = row;
  assign cmd_in.col   = col;
  assign cmd_in.value = value;

  mmt_fifo #(
    .WIDTH($bits(mmt_pkg::cmd_t)),
    .DEPTH(mmt_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push && keep),
    .din  (cmd_in),
    .full (full),
    .pop  (cmd_pop),
    .dout (cmd),
    .empty(q_empty),
    .count(q_count)
  );

  assign cmd_valid = !q_empty;

endmodule

@@ rtl/core/mmt_back.sv @@
// Back end: operand stores, shared MAC sequencer and result queue.
`timescale 1ns / 1ps
module mmt_back #(
  parameter int MAX_DIM = mmt_pkg::MAX_DIM_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  mmt_pkg::cfg_t cfg,
  input  mmt_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  output mmt_pkg::res_t result,
  output logic          empty,
  input  logic          pop
);

  localparam int AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int IW = mmt_pkg::IDX_W;
  localparam int CW = $clog2(mmt_pkg::RES_DEPTH + 1);

  logic                              busy;
  logic [IW-1:0]                     i;
  logic [IW-1:0]                     j;
  logic [IW-1:0]                     t;
  logic [CW-1:0]                     inflight;
  logic [CW-1:0]                     res_count;
  logic                              res_full;
  logic [IW-1:0]                     klast;
  logic [IW-1:0]                     nlast;
  logic                              credit;
  logic                              issue;
  logic                              start;
  logic                              a_we;
  logic                              b_we;
  logic [AW-1:0]                     waddr;
  logic [IW-1:0]                     a_r;
  logic [IW-1:0]                     a_c;
  logic [IW-1:0]                     b_r;
  logic [IW-1:0]                     b_c;
  logic [AW-1:0]                     a_raddr;
  logic [AW-1:0]                     b_raddr;
  logic [mmt_pkg::VAL_W-1:0]         a_data;
  logic [mmt_pkg::VAL_W-1:0]         b_data;

  logic                              s1_valid;
  logic                              s1_first;
  logic                              s1_lastk;
  logic                              s1_lastc;
  logic                              s1_zero;
  logic [IW-1:0]                     s1_row;
  logic [IW-1:0]                     s1_col;
  logic                              s2_valid;
  logic                              s2_first;
  logic                              s2_lastk;
  logic                              s2_lastc;
  logic [IW-1:0]                     s2_row;
  logic [IW-1:0]                     s2_col;
  logic signed [mmt_pkg::PROD_W-1:0] s2_prod;
  logic signed [mmt_pkg::ACC_W-1:0]  acc;
  logic signed [mmt_pkg::ACC_W-1:0]  acc_next;
  logic                              res_push;
  mmt_pkg::res_t                     res_in;

  assign klast  = (cfg.k == '0) ? '0 : IW'(cfg.k - 1'b1);
  assign nlast  = IW'(cfg.n - 1'b1);
  assign credit = ({1'b0, res_count} + {1'b0, inflight}) < (CW + 1)'(mmt_pkg::RES_DEPTH);
  assign issue  = busy && ((t != '0) || credit);
  assign cmd_pop = !busy && cmd_valid;

  always_comb begin
    a_we  = 1'b0;
    b_we  = 1'b0;
    start = 1'b0;
    if (cmd_pop) begin
      unique case (cmd.op)
        mmt_pkg::KIND_WR_A: a_we = 1'b1;
        mmt_pkg::KIND_WR_B: b_we = 1'b1;
        mmt_pkg::KIND_ROW:  start = 1'b1;
        default:            start = 1'b0;
      endcase
    end
  end

  assign waddr = AW'(cmd.row) * AW'(MAX_DIM) + AW'(cmd.col);

  always_comb begin
    a_r = (cfg.md == mmt_pkg::MODE_ATB) ? t : i;
    a_c = (cfg.md == mmt_pkg::MODE_ATB) ? i : t;
    b_r = (cfg.md == mmt_pkg::MODE_ABT) ? j : t;
    b_c = (cfg.md == mmt_pkg::MODE_ABT) ? t : j;
  end

  assign a_raddr = AW'(a_r) * AW'(MAX_DIM) + AW'(a_c);
  assign b_raddr = AW'(b_r) * AW'(MAX_DIM) + AW'(b_c);

  mmt_ram #(
    .WIDTH(mmt_pkg::VAL_W),
    .DEPTH(MAX_DIM * MAX_DIM)
  ) u_a_ram (
    .clk  (clk),
    .we   (a_we),
    .waddr(waddr),
    .wdata(cmd.value),
    .raddr(a_raddr),
    .rdata(a_data)
  );

  mmt_ram #(
    .WIDTH(mmt_pkg::VAL_W),
    .DEPTH(MAX_DIM * MAX_DIM)
  ) u_b_ram (
    .clk  (clk),
    .we   (b_we),
    .waddr(waddr),
    .wdata(cmd.value),
    .raddr(b_raddr),
    .rdata(b_data)
  );

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      j        <= '0;
      t        <= '0;
      inflight <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      inflight <= inflight + CW'(issue && (t == '0)) - CW'(res_push);
      if (start) begin
        busy <= 1'b1;
        j    <= '0;
        t    <= '0;
      end else if (issue) begin
        if (t == klast) begin
          t <= '0;
          j <= j + 1'b1;
          if (j == nlast) begin
            busy <= 1'b0;
          end
        end else begin
          t <= t + 1'b1;
        end
      end
    end
  end

  // datapath: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      i <= cmd.row;
    end
    if (issue) begin
      s1_first <= (t == '0);
      s1_lastk <= (t == klast);
      s1_lastc <= (j == nlast);
      s1_zero  <= (cfg.k == '0);
      s1_row   <= i;
      s1_col   <= j;
    end
    if (s1_valid) begin
      s2_first <= s1_first;
      s2_lastk <= s1_lastk;
      s2_lastc <= s1_lastc;
      s2_row   <= s1_row;
      s2_col   <= s1_col;
      if (s1_zero) begin
        s2_prod <= '0;
      end else begin
        s2_prod <= $signed(a_data) * $signed(b_data);
      end
    end
    if (s2_valid) begin
      acc <= acc_next;
    end
  end

  assign acc_next = (s2_first ? '0 : acc) + mmt_pkg::ACC_W'(s2_prod);
  assign res_push = s2_valid && s2_lastk;

  assign res_in.row   = s2_row;
  assign res_in.col   = s2_col;
  assign res_in.value = acc_next;
  assign res_in.last  = s2_lastc;

  mmt_fifo #(
    .WIDTH($bits(mmt_pkg::res_t)),
    .DEPTH(mmt_pkg::RES_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_in),
    .full (res_full),
    .pop  (pop),
    .dout (result),
    .empty(empty),
    .count(res_count)
  );

endmodule

@@ rtl/core/matrix_multiply_with_transpose_modes.sv @@
// Matrix multiply with transpose modes: C = A*B, A^T*B or A*B^T over Q1.15
// operands, one row of C per compute beat. Load beats write one element of A
// or B; loads outside the configured shape and compute rows at or beyond M or
// with N zero are dropped in the front end. A compute beat holds the back end
// until its N*max(K,1) products issue, pausing before each element while the
// result queue lacks room, as a single 16x16 multiply-accumulate unit fed by one
// read port per operand store does every product. Each element goes through
// the read and multiply registers into the result queue. Results are exact
// 36-bit sums with 30 fraction bits, in column order, with last set on column
// N-1. A two-entry command queue lets the input side keep taking beats while
// the back end works, and a four-entry result queue absorbs output stalls.
// Config registers may change only while the block is idle.
`timescale 1ns / 1ps
`include "matrix_multiply_with_transpose_modes_defines.svh"
module matrix_multiply_with_transpose_modes #(
  parameter int MAX_DIM = mmt_pkg::MAX_DIM_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [mmt_pkg::DIM_W-1:0]         cfg_data,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        kind,
  input  logic [mmt_pkg::IDX_W-1:0]         row,
  input  logic [mmt_pkg::IDX_W-1:0]         col,
  input  logic signed [mmt_pkg::VAL_W-1:0]  value,
  output logic                              empty,
  input  logic                              pop,
  output logic [mmt_pkg::IDX_W-1:0]         out_row,
  output logic [mmt_pkg::IDX_W-1:0]         out_col,
  output logic signed [mmt_pkg::ACC_W-1:0]  out_value,
  output logic                              last
);

  localparam int DIM_CAP = (MAX_DIM < mmt_pkg::FIELD_CAP) ? MAX_DIM : mmt_pkg::FIELD_CAP;
  localparam logic [mmt_pkg::DIM_W-1:0] CAP = mmt_pkg::DIM_W'(DIM_CAP);

  logic [1:0]                mode;
  logic [mmt_pkg::DIM_W-1:0] rows_m;
  logic [mmt_pkg::DIM_W-1:0] inner_k;
  logic [mmt_pkg::DIM_W-1:0] cols_n;
  mmt_pkg::cfg_t             cfg;
  mmt_pkg::cmd_t             cmd;
  logic                      cmd_valid;
  logic                      cmd_pop;
  mmt_pkg::res_t             result;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= mmt_pkg::MODE_AB;
      rows_m  <= mmt_pkg::DIM_W'(mmt_pkg::FIELD_CAP);
      inner_k <= mmt_pkg::DIM_W'(mmt_pkg::FIELD_CAP);
      cols_n  <= mmt_pkg::DIM_W'(mmt_pkg::FIELD_CAP);
    end else if (cfg_we) begin
      unique case (mmt_pkg::cfg_reg_t'(cfg_index))
        mmt_pkg::REG_MODE:    mode    <= cfg_data[1:0];
        mmt_pkg::REG_ROWS_M:  rows_m  <= cfg_data;
        mmt_pkg::REG_INNER_K: inner_k <= cfg_data;
        mmt_pkg::REG_COLS_N:  cols_n  <= cfg_data;
        default:              mode    <= mode;
      endcase
    end
  end

  always_comb begin
    unique case (mode)
      mmt_pkg::MODE_ATB: cfg.md = mmt_pkg::MODE_ATB;
      mmt_pkg::MODE_ABT: cfg.md = mmt_pkg::MODE_ABT;
      default:           cfg.md = mmt_pkg::MODE_AB;
    endcase
    cfg.m = (rows_m > CAP) ? CAP : rows_m;
    cfg.k = (inner_k > CAP) ? CAP : inner_k;
    cfg.n = (cols_n > CAP) ? CAP : cols_n;
  end

  mmt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .kind     (kind),
    .row      (row),
    .col      (col),
    .value    (value),
    .cmd      (cmd),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop)
  );

  mmt_back #(
    .MAX_DIM(MAX_DIM)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

  assign out_row   = result.row;
  assign out_col   = result.col;
  assign out_value = result.value;
  assign last      = result.last;

  `MMT_ASSERT_ALWAYS(a_reset_drains, rst |=> empty, "result queue not empty after reset")
  `MMT_ASSERT(a_row_in_range, !empty |-> (5'(out_row) < cfg.m), "result row beyond M")
  `MMT_ASSERT(a_col_in_range, !empty |-> (5'(out_col) < cfg.n), "result column beyond N")
  `MMT_ASSERT(a_last_at_end, (!empty && last) |-> (5'(out_col) + 5'd1 == cfg.n), "last beat not on final column")

endmodule
